// ----- hdl/spatial_equal_power_pan_macros.svh -----
// assertion helpers
`ifndef SPATIAL_EQUAL_POWER_PAN_MACROS_SVH
`define SPATIAL_EQUAL_POWER_PAN_MACROS_SVH
`define SEPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define SEPP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/sepp_pkg.sv -----
package sepp_pkg;
	localparam int unsigned TBL_BITS = 10;
	localparam int unsigned TBL_SIZE = 1 << TBL_BITS;
	localparam logic [16:0] Q15_ONE = 17'd32768;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned SQ_BITS = 32;

	typedef enum logic [0:0] {
		REG_PAN_WIDTH = 1'b0,
		REG_AXIS_EPS  = 1'b1
	} reg_idx_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic        neg_x;
		logic        behind;
		logic        centred;
		logic [15:0] ax;
		logic [15:0] az;
		logic [16:0] gain;
		logic [16:0] width;
		logic [7:0]  eps;
	} item_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic empty;
		logic full;
	} q_ctl_t;

	// Q15 quarter sine, computed with an integer series
	function automatic logic [15:0] quarter_sine(input int unsigned k);
		longint unsigned x, x2, f, r;
		x  = (longint'(k) * 64'd1686629713) >> TBL_BITS;
		x2 = (x * x) >> 30;
		f  = 64'd1073741824 - x2 / 110;
		f  = 64'd1073741824 - ((x2 * f) >> 30) / 72;
		f  = 64'd1073741824 - ((x2 * f) >> 30) / 42;
		f  = 64'd1073741824 - ((x2 * f) >> 30) / 20;
		f  = 64'd1073741824 - ((x2 * f) >> 30) / 6;
		r  = (x * f) >> 30;
		r  = (r + 64'd16384) >> 15;
		if (r > 64'd32768)
			r = 64'd32768;
		return r[15:0];
	endfunction
endpackage

// ----- hdl/sepp_front.sv -----
module sepp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   side_pos,
	input  logic signed [15:0]   forward_pos,
	input  logic [15:0]          source_gain,
	input  logic [15:0]          pan_width_q,
	input  logic [7:0]           axis_eps_q,
	output logic                 vld_s1,
	output sepp_pkg::item_t      item_s1
);
	logic [15:0] ax, az;
	always_comb begin
		ax = side_pos[15] ? 16'(-side_pos) : side_pos;
		az = forward_pos[15] ? 16'(-forward_pos) : forward_pos;
	end
	logic [31:0] r2, e2;
	always_comb begin
		r2 = 32'(ax) * 32'(ax) + 32'(az) * 32'(az);
		e2 = 32'(axis_eps_q) * 32'(axis_eps_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		item_s1.neg_x   <= side_pos[15];
		item_s1.behind  <= forward_pos[15];
		item_s1.centred <= (r2 == 32'd0) || (r2 < e2);
		item_s1.ax      <= ax;
		item_s1.az      <= az;
		item_s1.gain    <= ({1'b0, source_gain} > sepp_pkg::Q15_ONE) ?
			sepp_pkg::Q15_ONE : {1'b0, source_gain};
		item_s1.width   <= ({1'b0, pan_width_q} > sepp_pkg::Q15_ONE) ?
			sepp_pkg::Q15_ONE : {1'b0, pan_width_q};
		item_s1.eps     <= axis_eps_q;
	end
endmodule

// ----- hdl/sepp_queue.sv -----
module sepp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  sepp_pkg::item_t wdata,
	input  logic            rd,
	output logic            empty,
	output sepp_pkg::item_t rdata
);
	localparam int unsigned AW = $clog2(sepp_pkg::Q_DEPTH);
	sepp_pkg::item_t mem_q [sepp_pkg::Q_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
	`include "spatial_equal_power_pan_macros.svh"
	`SEPP_ASSERT_IMP(a_no_underflow, rd, !empty, "queue read when empty")
	`SEPP_ASSERT_IMP(a_no_overflow, wr && !rd, cnt_q < (AW+1)'(sepp_pkg::Q_DEPTH), "queue overflow")
	`SEPP_ASSERT_NXT(a_cnt_hold, !wr && !rd, $stable(cnt_q), "count moved")
endmodule

// ----- hdl/sepp_back.sv -----
module sepp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  sepp_pkg::item_t item,
	output logic            done,
	output logic [15:0]     left_gain,
	output logic [15:0]     right_gain
);
	localparam int unsigned B = sepp_pkg::TBL_BITS;
	// sqrt of r2*2^30 (62 bits) -> 31-bit root, one root bit per stage
	localparam int unsigned SQS = 31;
	// shift-sub divide stages
	localparam int unsigned DVS = 16;
	// valid shift: sqrt, divide, then clamp, width-scale, lookup and gain stages
	localparam int unsigned PL = SQS + DVS + 4;

	typedef struct packed {
		logic        neg_x;
		logic        behind;
		logic        centred;
		logic [15:0] ax;
		logic [15:0] az;
		logic [16:0] gain;
		logic [16:0] width;
		logic [7:0]  eps;
	} ctx_t;

	logic [PL-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else
			v_q <= {v_q[PL-2:0], in_vld};
	end

	ctx_t         sc_q [SQS+1];
	logic [63:0]  sr_q [SQS+1];
	logic [31:0]  sq_q [SQS+1];
	always_comb begin
		sc_q[0] = item;
		sr_q[0] = 64'(32'(item.ax) * 32'(item.ax) + 32'(item.az) * 32'(item.az)) << 30;
		sq_q[0] = '0;
	end
	for (genvar i = 0; i < SQS; i++) begin : g_sqrt
		logic [63:0] trial;
		logic [63:0] bitv;
		assign bitv = 64'd1 << (2 * (SQS - 1 - i));
		assign trial = {31'd0, sq_q[i], 1'b0} << (SQS - 1 - i);
		always_ff @(posedge clk) begin
			sc_q[i+1] <= sc_q[i];
			if (sr_q[i] >= trial + bitv) begin
				sr_q[i+1] <= sr_q[i] - trial - bitv;
				sq_q[i+1] <= sq_q[i] | (32'd1 << (SQS - 1 - i));
			end else begin
				sr_q[i+1] <= sr_q[i];
				sq_q[i+1] <= sq_q[i];
			end
		end
	end

	// divides: s = (ax<<30)/m limited to 2^15 (16 quotient bits),
	// shadow quotient = az*8192/(ax+az+eps) (< 8192 when eps is nonzero, 14 bits)
	ctx_t        dc_q [DVS+1];
	logic [47:0] dn_q [DVS+1];
	logic [31:0] dm_q [DVS+1];
	logic [16:0] dq_q [DVS+1];
	logic [29:0] hn_q [DVS+1];
	logic [17:0] hd_q [DVS+1];
	logic [13:0] hq_q [DVS+1];
	always_comb begin
		dc_q[0] = sc_q[SQS];
		dm_q[0] = sq_q[SQS];
		dn_q[0] = 48'(sc_q[SQS].ax) << 30;
		dq_q[0] = '0;
		hn_q[0] = 30'(sc_q[SQS].az) << 13;
		hd_q[0] = 18'(sc_q[SQS].ax) + 18'(sc_q[SQS].az) + 18'(sc_q[SQS].eps);
		hq_q[0] = '0;
	end
	for (genvar i = 0; i < DVS; i++) begin : g_div
		localparam int unsigned SH = DVS - 1 - i;
		logic [63:0] dt;
		logic [47:0] ht;
		assign dt = 64'(dm_q[i]) << SH;
		assign ht = 48'(hd_q[i]) << SH;
		always_ff @(posedge clk) begin
			dc_q[i+1] <= dc_q[i];
			dm_q[i+1] <= dm_q[i];
			hd_q[i+1] <= hd_q[i];
			if (64'(dn_q[i]) >= dt && dm_q[i] != '0) begin
				dn_q[i+1] <= 48'(64'(dn_q[i]) - dt);
				dq_q[i+1] <= dq_q[i] | (17'd1 << SH);
			end else begin
				dn_q[i+1] <= dn_q[i];
				dq_q[i+1] <= dq_q[i];
			end
			if (SH < 14 && 48'(hn_q[i]) >= ht) begin
				hn_q[i+1] <= 30'(48'(hn_q[i]) - ht);
				hq_q[i+1] <= hq_q[i] | 14'(1 << SH);
			end else begin
				hn_q[i+1] <= hn_q[i];
				hq_q[i+1] <= hq_q[i];
			end
		end
	end

	// quotient of divide before stage 16 bits: true s may exceed 2^16 only when
	// upper stages would be needed; |x|/sqrt(x2+z2)<=1 so s<=2^15
	ctx_t        e1_c_s1;
	logic [16:0] e1_s_s1;
	logic [13:0] e1_h_s1;
	logic [33:0] e2_p_s2;
	ctx_t        e2_c_s2;
	logic [13:0] e2_h_s2;
	always_ff @(posedge clk) begin
		e1_c_s1 <= dc_q[DVS];
		e1_s_s1 <= dc_q[DVS].centred ? 17'd0 :
			((dq_q[DVS] > sepp_pkg::Q15_ONE) ? sepp_pkg::Q15_ONE : dq_q[DVS]);
		e1_h_s1 <= hq_q[DVS];
		e2_p_s2 <= 34'(e1_s_s1) * 34'(e1_c_s1.width) + 34'd16384;
		e2_c_s2 <= e1_c_s1;
		e2_h_s2 <= e1_h_s1;
	end
	logic [17:0] amag, u;
	logic [B:0]  idx;
	logic [17:0] idx_w;
	always_comb begin
		amag = 18'(e2_p_s2 >> 15);
		u = e2_c_s2.neg_x ? 18'd32768 - amag : 18'd32768 + amag;
		idx_w = (u + 18'(1 << (15 - B))) >> (16 - B);
		idx = (idx_w > 18'(sepp_pkg::TBL_SIZE)) ? (B+1)'(sepp_pkg::TBL_SIZE) : idx_w[B:0];
	end
	logic [15:0] sin_tbl [sepp_pkg::TBL_SIZE+1];
	for (genvar k = 0; k <= sepp_pkg::TBL_SIZE; k++) begin : g_tbl
		assign sin_tbl[k] = sepp_pkg::quarter_sine(k);
	end
	logic [15:0] sq_s3, cq_s3;
	ctx_t        c_s3;
	logic [13:0] h_s3;
	always_ff @(posedge clk) begin
		sq_s3 <= sin_tbl[idx];
		cq_s3 <= sin_tbl[(B+1)'(sepp_pkg::TBL_SIZE) - idx];
		c_s3 <= e2_c_s2;
		h_s3 <= e2_h_s2;
	end
	logic [16:0] l_s4, r_s4, sh_s4;
	logic        bh_s4;
	logic [33:0] lp, rp;
	always_comb begin
		lp = 34'(cq_s3) * 34'(c_s3.gain) + 34'd16384;
		rp = 34'(sq_s3) * 34'(c_s3.gain) + 34'd16384;
	end
	always_ff @(posedge clk) begin
		l_s4 <= 17'(lp >> 15);
		r_s4 <= 17'(rp >> 15);
		sh_s4 <= sepp_pkg::Q15_ONE - 17'(h_s3);
		bh_s4 <= c_s3.behind;
	end
	logic [33:0] lf, rf;
	logic [16:0] lo, ro;
	always_comb begin
		lf = (34'(l_s4) * 34'(sh_s4) + 34'd16384) >> 15;
		rf = (34'(r_s4) * 34'(sh_s4) + 34'd16384) >> 15;
		lo = bh_s4 ? 17'(lf) : l_s4;
		ro = bh_s4 ? 17'(rf) : r_s4;
	end
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= v_q[SQS + DVS + 3];
	end
	always_ff @(posedge clk) begin
		left_gain  <= (lo > sepp_pkg::Q15_ONE) ? 16'd32768 : lo[15:0];
		right_gain <= (ro > sepp_pkg::Q15_ONE) ? 16'd32768 : ro[15:0];
	end
	assign done = done_q;
endmodule

// ----- hdl/spatial_equal_power_pan.sv -----
// Path: done rises after the front register at the accepting edge, the queue,
// 31 sqrt stages, 16 divide, 4 scale/lookup/gain and the output register.
// Throughput: one transaction per cycle; the back end never stalls since the
// receiver cannot hold results off.
// Reset: pan_width returns to 32768, axis_epsilon to 1, pipeline emptied.
module spatial_equal_power_pan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  side_pos,
	input  logic signed [15:0]  forward_pos,
	input  logic [15:0]         source_gain,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output logic [15:0]         left_gain,
	output logic [15:0]         right_gain
);
	logic [15:0] pan_width_q;
	logic [7:0]  axis_eps_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_width_q <= 16'd32768;
			axis_eps_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (sepp_pkg::reg_idx_t'(cfg_idx))
				sepp_pkg::REG_PAN_WIDTH: pan_width_q <= cfg_data;
				sepp_pkg::REG_AXIS_EPS:  axis_eps_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end
	assign busy = 1'b0;
	logic            f_vld;
	sepp_pkg::item_t f_item, q_item;
	sepp_pkg::q_ctl_t qc;
	sepp_front u_front (
		.clk, .arst_n, .start(start && !busy), .side_pos, .forward_pos, .source_gain,
		.pan_width_q, .axis_eps_q, .vld_s1(f_vld), .item_s1(f_item)
	);
	assign qc.wr = f_vld;
	assign qc.rd = !qc.empty;
	assign qc.full = 1'b0;
	sepp_queue u_queue (
		.clk, .arst_n, .wr(qc.wr), .wdata(f_item), .rd(qc.rd), .empty(qc.empty),
		.rdata(q_item)
	);
	sepp_back u_back (
		.clk, .arst_n, .in_vld(qc.rd), .item(q_item), .done, .left_gain, .right_gain
	);
endmodule
